FILE: hdl/sqn_pkg.sv
// Package for the SQL query normalizer: beat types used by the interfaces,
// character codes and the per-byte normalization step used by the step stage.
// No dependencies.
`default_nettype none

package sqn_pkg;

    // Character codes
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CASE_OFS  = 8'h20;

    // Most characters one input byte can produce
    localparam int MAX_CHARS = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } sqn_in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       run_end;
        logic       query_end;
    } sqn_out_beat_t;

    typedef struct packed {
        logic [7:0] previous_byte;
        logic       inside_literal;
        logic       literal_is_double_quote;
        logic       inside_number;
        logic       space_pending;
        logic       minus_pending;
        logic       emitted_any;
    } sqn_state_t;

    // Characters produced by one byte, handed from step stage to emitter
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [1:0]                nbeat;   // beats in the group, 1..3
        logic                      marker;  // bare end marker, no character
        logic                      last;    // group closes the query
    } sqn_group_t;

    // Working record while one byte is processed
    typedef struct packed {
        sqn_state_t                st;
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [1:0]                cnt;
    } sqn_work_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic sqn_work_t put_char(sqn_work_t w, logic [7:0] c);
        sqn_work_t r;
        r = w;
        if (r.cnt != 2'd3)
        begin
            r.chars[r.cnt] = c;
            r.cnt          = r.cnt + 2'd1;
        end
        r.st.emitted_any = 1'b1;
        return r;
    endfunction

    function automatic sqn_work_t flush_space(sqn_work_t w);
        sqn_work_t r;
        r = w;
        if (r.st.space_pending)
        begin
            r.st.space_pending = 1'b0;
            r = put_char(r, CH_SPACE);
        end
        return r;
    endfunction

    // Ordinary handling of a byte outside a literal and without a pending minus
    function automatic sqn_work_t process_plain(sqn_work_t w, logic [7:0] b, logic last);
        sqn_work_t r;
        logic      absorbed;
        r        = w;
        absorbed = 1'b0;
        if (r.st.inside_number)
        begin
            if (is_digit(b) || (b == CH_DOT) || (b == CH_MINUS))
                absorbed = 1'b1;
            else
                r.st.inside_number = 1'b0;
        end
        if (!absorbed)
        begin
            if (((b == CH_SQUOTE) || (b == CH_DQUOTE)) && (r.st.previous_byte != CH_BSLASH))
            begin
                r = flush_space(r);
                r = put_char(r, CH_QMARK);
                r = put_char(r, CH_S);
                r.st.inside_literal          = 1'b1;
                r.st.literal_is_double_quote = (b == CH_DQUOTE);
            end
            else if (is_digit(b))
            begin
                r = flush_space(r);
                r = put_char(r, CH_QMARK);
                r = put_char(r, CH_N);
                r.st.inside_number = 1'b1;
            end
            else if (b == CH_MINUS)
            begin
                r = flush_space(r);
                if (last)
                    r = put_char(r, CH_MINUS);
                else
                    r.st.minus_pending = 1'b1;
            end
            else if (is_ws(b))
            begin
                if (r.st.emitted_any)
                    r.st.space_pending = 1'b1;
            end
            else
            begin
                r = flush_space(r);
                if ((b >= CH_LC_A) && (b <= CH_LC_Z))
                    r = put_char(r, b - CASE_OFS);
                else
                    r = put_char(r, b);
            end
        end
        return r;
    endfunction

    // Full step for one input byte: next state plus the characters it yields
    function automatic sqn_work_t norm_step(sqn_state_t s, logic [7:0] b, logic last);
        sqn_work_t  r;
        logic [7:0] q;
        r       = '0;
        r.st    = s;
        q       = s.literal_is_double_quote ? CH_DQUOTE : CH_SQUOTE;
        if (s.inside_literal)
        begin
            if ((b == q) && (s.previous_byte != CH_BSLASH))
                r.st.inside_literal = 1'b0;
        end
        else if (s.minus_pending)
        begin
            r.st.minus_pending = 1'b0;
            if (is_digit(b))
            begin
                r = put_char(r, CH_QMARK);
                r = put_char(r, CH_N);
                r.st.inside_number = 1'b1;
            end
            else
            begin
                r = put_char(r, CH_MINUS);
                r = process_plain(r, b, last);
            end
        end
        else
        begin
            r = process_plain(r, b, last);
        end
        r.st.previous_byte = b;
        if (last)
            r.st = '0;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/sqn_if.sv
// Valid/ready channel interfaces for the SQL query normalizer.
// Depends on sqn_pkg for the beat types.
`default_nettype none

interface sqn_in_if import sqn_pkg::*; ();
    logic         valid;
    logic         ready;
    sqn_in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sqn_out_if import sqn_pkg::*; ();
    logic          valid;
    logic          ready;
    sqn_out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/sqn_step.sv
// Input register, normalizer state and per-byte step logic.
// Depends on sqn_pkg and sqn_in_if; hands a group onward per byte with output.
`default_nettype none

module sqn_step import sqn_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sqn_in_if.sink     in_ch,
    output sqn_group_t group,
    output logic       group_valid,
    input  wire logic  group_ready
);

    logic         a_valid_reg;
    logic         a_valid_next;
    sqn_in_beat_t a_beat_reg;
    sqn_state_t   state_reg;
    sqn_work_t    work;
    logic         has_beats;
    logic         a_move;
    logic         in_fire;

    // Step logic on the registered byte
    always_comb
    begin
        work      = norm_step(state_reg, a_beat_reg.in_byte, a_beat_reg.last_byte);
        has_beats = (work.cnt != 2'd0) || a_beat_reg.last_byte;

        group.chars  = work.chars;
        group.marker = (work.cnt == 2'd0);
        group.nbeat  = (work.cnt == 2'd0) ? 2'd1 : work.cnt;
        group.last   = a_beat_reg.last_byte;
        group_valid  = a_valid_reg && has_beats;

        // bytes with no output leave without waiting for the emitter
        a_move       = a_valid_reg && (!has_beats || group_ready);
        in_ch.ready  = !a_valid_reg || a_move;
        in_fire      = in_ch.valid && in_ch.ready;
        a_valid_next = in_fire || (a_valid_reg && !a_move);
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (a_move)
                state_reg <= work.st;
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (in_fire)
            a_beat_reg <= in_ch.data;
    end

endmodule

`default_nettype wire

FILE: hdl/sqn_emit.sv
// Result register: holds one character group and sends it one beat at a time.
// Depends on sqn_pkg and sqn_out_if.
`default_nettype none

module sqn_emit import sqn_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  sqn_group_t group,
    input  wire logic  group_valid,
    output logic       group_ready,
    sqn_out_if.source  out_ch
);

    sqn_group_t g_reg;
    logic       g_valid_reg;
    logic [1:0] idx_reg;
    logic       final_beat;
    logic       out_fire;
    logic       load;

    // Current beat
    always_comb
    begin
        final_beat  = (idx_reg == (g_reg.nbeat - 2'd1));
        out_fire    = out_ch.valid && out_ch.ready;
        group_ready = !g_valid_reg || (out_fire && final_beat);
        load        = group_valid && group_ready;

        out_ch.valid          = g_valid_reg;
        out_ch.data.out_byte  = g_reg.marker ? 8'h00 : g_reg.chars[idx_reg];
        out_ch.data.out_valid = !g_reg.marker;
        out_ch.data.run_end   = final_beat;
        out_ch.data.query_end = final_beat && g_reg.last;
    end

    // Beat sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end
        else if (load)
        begin
            g_valid_reg <= 1'b1;
            idx_reg     <= 2'd0;
        end
        else if (out_fire)
        begin
            if (final_beat)
                g_valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    // Group payload
    always_ff @(posedge clk)
    begin
        if (load)
            g_reg <= group;
    end

endmodule

`default_nettype wire

FILE: hdl/sql_query_normalizer_top.sv
// An accepted byte is held in the sqn_step input register, then its group in
// the sqn_emit result register, which offers its first result beat. One byte
// per cycle unless the output stalls; multi-character bytes stall input
// briefly. The rate is set by the single-beat output of the result register.
// Reset (rst_n, async low) empties both registers and clears the query state.
// Depends on sqn_pkg, sqn_if, sqn_step and sqn_emit.
`default_nettype none

module sql_query_normalizer_top import sqn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sqn_in_if.sink    in_ch,
    sqn_out_if.source out_ch
);

    sqn_group_t group;
    logic       group_valid;
    logic       group_ready;

    sqn_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .group       (group),
        .group_valid (group_valid),
        .group_ready (group_ready)
    );

    sqn_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .group       (group),
        .group_valid (group_valid),
        .group_ready (group_ready),
        .out_ch      (out_ch)
    );

endmodule

`default_nettype wire

FILE: hdl/sqn_checker.sv
// Port-level checks for the SQL query normalizer and their bind to the top.
// Depends on sql_query_normalizer_top port names.
`default_nettype none

module sqn_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       valid,
    input wire logic       ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_valid,
    input wire logic       run_end,
    input wire logic       query_end
);

    // a stalled beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("output beat dropped while stalled");

    // a stalled beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable(out_byte) && $stable(out_valid)
                            && $stable(run_end) && $stable(query_end))
        else $error("output payload changed while stalled");

    // a bare end marker is always the final beat of a query with a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !out_valid |-> run_end && query_end && (out_byte == 8'h00))
        else $error("malformed end marker");

    // the query ends only on the last beat of a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && query_end |-> run_end)
        else $error("query end without run end");

endmodule

bind sql_query_normalizer_top sqn_checker u_sqn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (out_ch.valid),
    .ready     (out_ch.ready),
    .out_byte  (out_ch.data.out_byte),
    .out_valid (out_ch.data.out_valid),
    .run_end   (out_ch.data.run_end),
    .query_end (out_ch.data.query_end)
);

`default_nettype wire

FILE: bench/sqn_norm_compare.sv
// Result predictor and comparator for the SQL query normalizer bench.
// Watches both channels, predicts normalized text per accepted input beat.
// Depends on sqn_pkg and sqn_if.
`timescale 1ns / 1ps

module sqn_norm_compare import sqn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sqn_in_if    in_mon,
    sqn_out_if   out_mon,
    output int   fail_count,
    output int   open_beats
);

    // Predicted query state
    logic [7:0] prev_raw;
    bit         in_lit;
    bit         lit_dq;
    bit         in_num;
    bit         space_owed;
    bit         minus_held;
    bit         wrote_any;

    // Characters produced by the current input beat
    logic [7:0] char_buf [3];
    int         char_cnt;

    sqn_out_beat_t norm_chars_due [$];
    sqn_out_beat_t got_beat;
    sqn_out_beat_t want_beat;
    int            report_cnt;

    function automatic bit dig(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic bit blank(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function void clear_query();
        prev_raw   = '0;
        in_lit     = 1'b0;
        lit_dq     = 1'b0;
        in_num     = 1'b0;
        space_owed = 1'b0;
        minus_held = 1'b0;
        wrote_any  = 1'b0;
    endfunction

    function void put(logic [7:0] c);
        if (char_cnt < 3)
        begin
            char_buf[char_cnt] = c;
            char_cnt++;
        end
        wrote_any = 1'b1;
    endfunction

    function void pay_space();
        if (space_owed)
        begin
            space_owed = 1'b0;
            put(CH_SPACE);
        end
    endfunction

    // Byte outside a literal with no minus waiting
    function void plain_char(logic [7:0] b, bit last);
        if (in_num)
        begin
            if (dig(b) || (b == CH_DOT) || (b == CH_MINUS))
                return;
            in_num = 1'b0;
        end
        if (((b == CH_SQUOTE) || (b == CH_DQUOTE)) && (prev_raw != CH_BSLASH))
        begin
            pay_space();
            put(CH_QMARK);
            put(CH_S);
            in_lit = 1'b1;
            lit_dq = (b == CH_DQUOTE);
        end
        else if (dig(b))
        begin
            pay_space();
            put(CH_QMARK);
            put(CH_N);
            in_num = 1'b1;
        end
        else if (b == CH_MINUS)
        begin
            pay_space();
            if (last)
                put(CH_MINUS);
            else
                minus_held = 1'b1;
        end
        else if (blank(b))
        begin
            if (wrote_any)
                space_owed = 1'b1;
        end
        else
        begin
            pay_space();
            if ((b >= CH_LC_A) && (b <= CH_LC_Z))
                put(b - CASE_OFS);
            else
                put(b);
        end
    endfunction

    // Queue the beats one input byte yields
    function void predict_norm(logic [7:0] b, bit last);
        logic [7:0]    closer;
        sqn_out_beat_t e;
        char_cnt = 0;
        if (in_lit)
        begin
            closer = lit_dq ? CH_DQUOTE : CH_SQUOTE;
            if ((b == closer) && (prev_raw != CH_BSLASH))
                in_lit = 1'b0;
        end
        else if (minus_held)
        begin
            minus_held = 1'b0;
            if (dig(b))
            begin
                put(CH_QMARK);
                put(CH_N);
                in_num = 1'b1;
            end
            else
            begin
                put(CH_MINUS);
                plain_char(b, last);
            end
        end
        else
        begin
            plain_char(b, last);
        end
        prev_raw = b;

        if (last)
        begin
            clear_query();
            if (char_cnt == 0)
            begin
                // bare end marker
                e.out_byte  = '0;
                e.out_valid = 1'b0;
                e.run_end   = 1'b1;
                e.query_end = 1'b1;
                norm_chars_due.push_back(e);
            end
        end
        for (int k = 0; k < char_cnt; k++)
        begin
            e.out_byte  = char_buf[k];
            e.out_valid = 1'b1;
            e.run_end   = (k == char_cnt - 1);
            e.query_end = (k == char_cnt - 1) && last;
            norm_chars_due.push_back(e);
        end
    endfunction

    function void report(sqn_out_beat_t want, sqn_out_beat_t got, bit stray);
        fail_count++;
        if (report_cnt < 10)
        begin
            report_cnt++;
            if (stray)
                $display("%0t: unexpected beat byte=%h valid=%b run_end=%b query_end=%b",
                         $realtime, got.out_byte, got.out_valid, got.run_end, got.query_end);
            else
                $display({"%0t: mismatch exp byte=%h valid=%b run_end=%b query_end=%b,",
                          " got byte=%h valid=%b run_end=%b query_end=%b"},
                         $realtime, want.out_byte, want.out_valid, want.run_end,
                         want.query_end, got.out_byte, got.out_valid, got.run_end,
                         got.query_end);
        end
    endfunction

    initial
    begin
        fail_count = 0;
        report_cnt = 0;
        open_beats = 0;
        clear_query();
    end

    // Compare output beats first, then predict from the input beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                got_beat = out_mon.data;
                if (norm_chars_due.size() == 0)
                begin
                    report(got_beat, got_beat, 1'b1);
                end
                else
                begin
                    want_beat = norm_chars_due.pop_front();
                    if ((got_beat.out_byte !== want_beat.out_byte) ||
                        (got_beat.out_valid !== want_beat.out_valid) ||
                        (got_beat.run_end !== want_beat.run_end) ||
                        (got_beat.query_end !== want_beat.query_end))
                        report(want_beat, got_beat, 1'b0);
                end
            end
            if (in_mon.valid && in_mon.ready)
                predict_norm(in_mon.data.in_byte, in_mon.data.last_byte);
        end
        open_beats = norm_chars_due.size();
    end

endmodule

FILE: bench/sql_query_normalizer_top_tb.sv
// Testbench top for the SQL query normalizer: clock, reset, query stimulus,
// output back-pressure and the verdict. Depends on sqn_pkg, sqn_if,
// sql_query_normalizer_top and sqn_norm_compare.
`timescale 1ns / 1ps

module sql_query_normalizer_top_tb;
    import sqn_pkg::*;

    logic clk;
    logic rst_n;

    sqn_in_if  in_ch ();
    sqn_out_if out_ch ();

    int fail_count;
    int open_beats;

    // Idle control shared by sender and receiver
    int phase;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_left;
    bit held_once;

    int         bytes_sent;
    logic [7:0] text_q [$];

    sql_query_normalizer_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    sqn_norm_compare cmp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .fail_count (fail_count),
        .open_beats (open_beats)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(64'd2_000_000);
        $display("simulation failed");
        $finish;
    end

    // Output side: random stalls, one long hold-off in the receiver phase
    initial
    begin
        out_ch.ready = 1'b0;
        hold_left    = 0;
        held_once    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if ((phase == 1) && !held_once)
            begin
                held_once = 1'b1;
                hold_left = 60;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // One input beat, with an optional idle gap ahead of it
    task automatic put_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data.in_byte   <= b;
        in_ch.data.last_byte <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            put_beat(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic send_str(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
        send_text();
    endtask

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? CH_LC_A : CH_LC_A - CASE_OFS)
               + 8'($urandom_range(0, 25));
    endfunction

    // Append one random token of query text
    task automatic add_token();
        int         kind;
        int         n;
        logic [7:0] q;
        logic [7:0] c;
        string      punct;
        punct = "(),=<>*;+";
        kind  = $urandom_range(0, 99);
        if (kind < 25)
        begin
            // identifier or keyword, mixed case
            n = $urandom_range(1, 5);
            repeat (n) text_q.push_back(rand_letter());
        end
        else if (kind < 42)
        begin
            // number, maybe negative, with dots and minus signs
            if ($urandom_range(0, 9) < 4)
                text_q.push_back(CH_MINUS);
            text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            n = $urandom_range(0, 3);
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0:       c = CH_DOT;
                    1:       c = CH_MINUS;
                    default: c = CH_ZERO + 8'($urandom_range(0, 9));
                endcase
                text_q.push_back(c);
            end
        end
        else if (kind < 57)
        begin
            // quoted literal, sometimes left open
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            text_q.push_back(q);
            n = $urandom_range(0, 4);
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0: text_q.push_back(rand_letter());
                    1: text_q.push_back((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
                    2:
                    begin
                        text_q.push_back(CH_BSLASH);
                        text_q.push_back(q);
                    end
                    default: text_q.push_back(CH_SPACE);
                endcase
            end
            if ($urandom_range(0, 99) < 85)
                text_q.push_back(q);
        end
        else if (kind < 75)
        begin
            // whitespace run
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                c = 8'($urandom_range(8, 13));
                text_q.push_back((c == 8'd8) ? CH_SPACE : c);
            end
        end
        else if (kind < 85)
        begin
            text_q.push_back(punct[$urandom_range(0, punct.len() - 1)]);
        end
        else if (kind < 90)
        begin
            text_q.push_back(CH_MINUS);
        end
        else if (kind < 93)
        begin
            // escaped quote outside a literal
            text_q.push_back(CH_BSLASH);
            text_q.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
        end
        else
        begin
            text_q.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        int rand_start;
        int ntok;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        phase        = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        bytes_sent   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: spacing, pending minus, escapes, literals, extremes
        send_str(" a-1 ");
        send_str("\\'b-c");
        send_str("\"'\"-");
        text_q = '{8'h01, CH_TAB, 8'hFF, CH_CR, CH_ZERO + 8'd7};
        send_text();
        send_str("'x");

        // Random queries through the idle phases
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < 420)
        begin
            phase = ((bytes_sent - rand_start) * 4) / 420;
            case (phase)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 69;
                end
                2:
                begin
                    tx_idle_pct  = 69;
                    rx_stall_pct = 0;
                end
                default:
                begin
                    tx_idle_pct  = 23;
                    rx_stall_pct = 23;
                end
            endcase
            text_q.delete();
            ntok = $urandom_range(1, 7);
            repeat (ntok) add_token();
            send_text();
        end
        in_ch.valid <= 1'b0;

        // Drain, then let stray beats show up
        while (open_beats != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
